[hw/rtl/pfa_pkg.sv]
// pfa_pkg: shared types and codes for the page frame allocator
// no dependencies

package pfa_pkg;

    typedef enum logic [1:0] {
        K_REGION = 2'd0,
        K_ENABLE = 2'd1,
        K_ALLOC  = 2'd2,
        K_FREE   = 2'd3
    } t_kind;

    localparam logic [2:0] ST_NONE     = 3'd0;
    localparam logic [2:0] ST_FREE     = 3'd1;
    localparam logic [2:0] ST_USED     = 3'd2;
    localparam logic [2:0] ST_RESERVED = 3'd3;
    localparam logic [2:0] ST_ACPI     = 3'd4;
    localparam logic [2:0] ST_NVS      = 3'd5;

    localparam logic [2:0] RT_RAM      = 3'd0;
    localparam logic [2:0] RT_RESERVED = 3'd1;
    localparam logic [2:0] RT_ACPI     = 3'd2;
    localparam logic [2:0] RT_NVS      = 3'd3;

    localparam int unsigned LOW_LIMIT  = 256;
    localparam logic [15:0] FIRST_RESET = 16'd256;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] start_frame;
        logic [16:0] frame_count;
        logic [2:0]  region_type;
    } t_in_item;

    typedef struct packed {
        logic [15:0] frame;
        logic        status;
    } t_out_item;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FILL,
        S_SCAN,
        S_SCAN_WAIT,
        S_DONE
    } t_state;

endpackage

[hw/rtl/pfa_ram.sv]
// pfa_ram: generic single-port-write, single-port-read synchronous ram
// registered read data; no dependencies

module pfa_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[hw/rtl/pfa_ctrl.sv]
// pfa_ctrl: sequencer for region marks, fills, first-fit scans and frees
// depends on pfa_pkg; drives one pfa_ram holding the frame status table

module pfa_ctrl #(
    parameter int FRAMES = 65536
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  pfa_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output pfa_pkg::t_out_item o_out_data,
    output logic               o_we,
    output logic [$clog2(FRAMES)-1:0] o_waddr,
    output logic [2:0]         o_wdata,
    output logic [$clog2(FRAMES)-1:0] o_raddr,
    input  logic [2:0]         i_rdata
);
    import pfa_pkg::*;

    localparam int AW = $clog2(FRAMES);
    // wide enough for frame counts and 16-bit starts at any table size
    localparam int PW = (AW + 1 > 17) ? AW + 1 : 17;
    localparam logic [PW-1:0] FR = PW'(FRAMES);

    t_state r_state, n_state;
    logic [PW-1:0] r_ptr, n_ptr;       // clear/fill address or scan address
    logic [PW-1:0] r_end, n_end;       // fill end or scan top
    logic [2:0]    r_code, n_code;
    logic [PW-1:0] r_run, n_run;
    logic [PW-1:0] r_n, n_n;
    logic          r_alloc, n_alloc;   // fill belongs to a found run
    logic          r_en, n_en;
    logic [PW-1:0] r_bump, n_bump;
    logic [PW-1:0] r_top, n_top;
    logic [PW-1:0] r_hint, n_hint;
    t_out_item     r_out, n_out;

    logic [PW:0]   w_end_raw;
    logic [PW-1:0] w_end_clip;

    always_comb begin
        w_end_raw  = (PW+1)'(i_in_data.start_frame) + (PW+1)'(i_in_data.frame_count);
        w_end_clip = (w_end_raw > (PW+1)'(FRAMES)) ? FR : w_end_raw[PW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ptr   <= '0;
            r_en    <= 1'b0;
            r_bump  <= PW'(FIRST_RESET);
            r_top   <= '0;
            r_hint  <= '0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            r_en    <= n_en;
            r_bump  <= n_bump;
            r_top   <= n_top;
            r_hint  <= n_hint;
        end
    end

    always_ff @(posedge i_clk) begin
        r_end   <= n_end;
        r_code  <= n_code;
        r_run   <= n_run;
        r_n     <= n_n;
        r_alloc <= n_alloc;
        r_out   <= n_out;
    end

    always_comb begin
        n_state = r_state;
        n_ptr   = r_ptr;
        n_end   = r_end;
        n_code  = r_code;
        n_run   = r_run;
        n_n     = r_n;
        n_alloc = r_alloc;
        n_en    = r_en;
        n_bump  = r_bump;
        n_top   = r_top;
        n_hint  = r_hint;
        n_out   = r_out;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_we    = 1'b0;
        o_waddr = r_ptr[AW-1:0];
        o_wdata = r_code;
        o_raddr = r_ptr[AW-1:0];

        if (i_cfg_we) begin
            if (!r_en) begin
                n_bump = PW'(i_cfg_wdata);
            end
        end

        case (r_state)
            S_CLEAR: begin
                o_we    = 1'b1;
                o_wdata = ST_NONE;
                n_ptr   = r_ptr + 1'b1;
                if (r_ptr == FR - 1'b1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_out   = '0;
                    n_state = S_DONE;
                    n_alloc = 1'b0;
                    case (t_kind'(i_in_data.kind))
                        K_REGION: begin
                            if (w_end_raw >= (PW+1)'(LOW_LIMIT)
                                    && i_in_data.region_type <= RT_NVS) begin
                                n_ptr   = PW'(i_in_data.start_frame);
                                n_end   = w_end_clip;
                                n_state = S_FILL;
                                case (i_in_data.region_type)
                                    RT_RAM:      n_code = ST_FREE;
                                    RT_RESERVED: n_code = ST_RESERVED;
                                    RT_ACPI:     n_code = ST_ACPI;
                                    default:     n_code = ST_NVS;
                                endcase
                                if (i_in_data.region_type == RT_RAM) begin
                                    n_top = w_end_clip;
                                end
                            end
                        end
                        K_ENABLE: begin
                            if (!r_en) begin
                                n_en   = 1'b1;
                                n_hint = r_bump;
                            end
                        end
                        K_ALLOC: begin
                            if (i_in_data.frame_count == '0) begin
                                n_out.status = 1'b1;
                            end else if (!r_en) begin
                                if ((PW+1)'(r_bump) + (PW+1)'(i_in_data.frame_count)
                                        > (PW+1)'(FRAMES)) begin
                                    n_out.status = 1'b1;
                                end else begin
                                    n_out.frame = r_bump[15:0];
                                    n_bump = PW'((PW+1)'(r_bump)
                                        + (PW+1)'(i_in_data.frame_count));
                                end
                            end else begin
                                n_ptr   = r_hint;
                                n_end   = (r_top > FR) ? FR : r_top;
                                n_run   = '0;
                                n_n     = PW'(i_in_data.frame_count);
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            n_ptr   = PW'(i_in_data.start_frame);
                            n_end   = w_end_clip;
                            n_code  = ST_FREE;
                            n_state = S_FILL;
                            if (r_hint > PW'(i_in_data.start_frame)) begin
                                n_hint = PW'(i_in_data.start_frame);
                            end
                        end
                    endcase
                end
            end
            S_FILL: begin
                if (r_ptr < r_end) begin
                    o_we  = 1'b1;
                    n_ptr = r_ptr + 1'b1;
                end else begin
                    if (r_alloc) begin
                        n_hint = r_end;
                    end
                    n_state = S_DONE;
                end
            end
            S_SCAN: begin
                // issue read of r_ptr; data arrives next cycle
                if (r_ptr < r_end) begin
                    n_state = S_SCAN_WAIT;
                end else begin
                    n_out.status = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_SCAN_WAIT: begin
                n_state = S_SCAN;
                n_ptr   = r_ptr + 1'b1;
                if (i_rdata == ST_FREE) begin
                    n_run = r_run + 1'b1;
                    if (r_run + 1'b1 == r_n) begin
                        // found: fill run with used, hint past it
                        n_end   = r_ptr + 1'b1;
                        n_ptr   = r_ptr + 1'b1 - r_n;
                        n_out.frame = n_ptr[15:0];
                        n_code  = ST_USED;
                        n_alloc = 1'b1;
                        n_state = S_FILL;
                    end
                end else begin
                    n_run = '0;
                end
            end
            S_DONE: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_out_data = r_out;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_in_ready)
        else $error("input taken while busy");
    a_out_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_state == S_DONE))
        else $error("result shown outside done");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");
    a_run_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN_WAIT) |-> (r_run < r_n))
        else $error("run count passed request");
endmodule

[hw/rtl/page_frame_allocator_core.sv]
// page_frame_allocator_core: top level; frame status table in one ram plus sequencer
// depends on pfa_pkg, pfa_ram, pfa_ctrl
// after reset a pass clears all FRAMES entries; no item is taken until it ends
// enable and bump allocation: result valid in the cycle after accept
// table allocation: a read and a wait state per frame scanned, then the run fill
// region/free: result after the fill; one item at a time; result held until taken

module page_frame_allocator_core #(
    parameter int FRAMES = 65536
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  pfa_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output pfa_pkg::t_out_item o_out_data
);
    import pfa_pkg::*;

    localparam int AW = $clog2(FRAMES);

    logic          w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [2:0]    w_wdata, w_rdata;

    pfa_ram #(.WIDTH(3), .DEPTH(FRAMES)) u_ram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr), .o_rdata(w_rdata)
    );

    pfa_ctrl #(.FRAMES(FRAMES)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .o_we(w_we), .o_waddr(w_waddr), .o_wdata(w_wdata),
        .o_raddr(w_raddr), .i_rdata(w_rdata)
    );
endmodule

[tb/sv/page_frame_allocator_core_tb.sv]
// page_frame_allocator_core_tb: self-checking testbench for the page frame allocator
// keeps its own copy of the frame status table and predicts every result item
// depends on pfa_pkg and page_frame_allocator_core

module page_frame_allocator_core_tb;
    import pfa_pkg::*;

    localparam int          NFRAMES     = 65536;
    localparam int unsigned CYCLE_LIMIT = 400000000;
    localparam int          N_RANDOM    = 1900;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_wdata = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_data;

    page_frame_allocator_core #(.FRAMES(NFRAMES)) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    // shadow allocator state
    logic [2:0]  shadow_status [0:NFRAMES-1];
    logic        shadow_table_on;
    int unsigned shadow_bump;
    int unsigned shadow_top;
    int unsigned shadow_hint;

    t_in_item  pending_items[$];
    t_out_item frame_result_q[$];

    int          error_count = 0;
    int          rx_count = 0;
    int          kind_count [0:3] = '{0, 0, 0, 0};
    int          alloc_fail_count = 0;
    int unsigned cycle_count = 0;

    function automatic int unsigned clip_end(int unsigned start, int unsigned count);
        int unsigned e;
        e = start + count;
        return (e > NFRAMES) ? NFRAMES : e;
    endfunction

    function automatic void mark_frames(int unsigned start, int unsigned count,
                                        logic [2:0] code);
        int unsigned e;
        e = clip_end(start, count);
        for (int unsigned k = start; k < e; k++) shadow_status[k] = code;
    endfunction

    function automatic t_out_item compute_frame_result(t_in_item it);
        t_out_item   res;
        int unsigned start;
        int unsigned count;
        int unsigned run;
        int unsigned top;
        int unsigned s;
        bit          found;
        res   = '0;
        start = it.start_frame;
        count = it.frame_count;
        found = 1'b0;
        case (t_kind'(it.kind))
            K_REGION: begin
                if (start + count >= LOW_LIMIT) begin
                    case (it.region_type)
                        RT_RAM: begin
                            mark_frames(start, count, ST_FREE);
                            shadow_top = clip_end(start, count);
                        end
                        RT_RESERVED: mark_frames(start, count, ST_RESERVED);
                        RT_ACPI:     mark_frames(start, count, ST_ACPI);
                        RT_NVS:      mark_frames(start, count, ST_NVS);
                        default: ;
                    endcase
                end
            end
            K_ENABLE: begin
                if (!shadow_table_on) begin
                    shadow_table_on = 1'b1;
                    shadow_hint = shadow_bump;
                end
            end
            K_ALLOC: begin
                if (count == 0) begin
                    found = 1'b0;
                end else if (!shadow_table_on) begin
                    if (shadow_bump + count <= NFRAMES) begin
                        res.frame = shadow_bump[15:0];
                        shadow_bump += count;
                        found = 1'b1;
                    end
                end else begin
                    top = (shadow_top > NFRAMES) ? NFRAMES : shadow_top;
                    run = 0;
                    for (int unsigned k = shadow_hint; k < top && !found; k++) begin
                        if (shadow_status[k] == ST_FREE) begin
                            run++;
                            if (run == count) begin
                                s = k + 1 - count;
                                mark_frames(s, count, ST_USED);
                                shadow_hint = k + 1;
                                res.frame = s[15:0];
                                found = 1'b1;
                            end
                        end else begin
                            run = 0;
                        end
                    end
                end
                if (!found) begin
                    res.frame  = '0;
                    res.status = 1'b1;
                    alloc_fail_count++;
                end
            end
            default: begin
                mark_frames(start, count, ST_FREE);
                if (shadow_hint > start) shadow_hint = start;
            end
        endcase
        kind_count[it.kind]++;
        return res;
    endfunction

    function automatic t_in_item mk_item(t_kind kind, int unsigned start,
                                         int unsigned count, int unsigned rtype);
        t_in_item it;
        it.kind        = kind;
        it.start_frame = start[15:0];
        it.frame_count = count[16:0];
        it.region_type = rtype[2:0];
        return it;
    endfunction

    function automatic int unsigned rand_count();
        int unsigned r;
        r = $urandom_range(0, 999);
        if (r < 3) return 65536;
        if (r < 7) return $urandom_range(0, 65535);
        if (r < 15) return 0;
        if (r < 700) return $urandom_range(1, 8);
        if (r < 950) return $urandom_range(9, 64);
        return $urandom_range(65, 512);
    endfunction

    function automatic t_in_item rand_item();
        int unsigned r;
        int unsigned start;
        int unsigned rtype;
        r = $urandom_range(0, 99);
        // low frames keep the scans short; the whole range now and then
        start = ($urandom_range(0, 99) < 5) ? $urandom_range(0, 65535)
                                             : $urandom_range(0, 2600);
        rtype = ($urandom_range(0, 99) < 20) ? $urandom_range(0, 7)
                                              : $urandom_range(0, 3);
        if (r < 25) return mk_item(K_REGION, start, rand_count(), rtype);
        if (r < 28) return mk_item(K_ENABLE, start, rand_count(), rtype);
        if (r < 66) return mk_item(K_ALLOC, start, rand_count(), rtype);
        return mk_item(K_FREE, start, rand_count(), rtype);
    endfunction

    // driver: bursts of items with random gaps
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                frame_result_q.push_back(compute_frame_result(i_in_data));
            end
            if (i_in_valid && !o_in_ready) begin
                i_in_valid <= 1'b1;
            end else if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                i_in_data  <= pending_items.pop_front();
                i_in_valid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 99) < 30) ? 0 : $urandom_range(1, 12);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // monitor: receiver stall pattern plus one long hold-off
    int  ready_pct = 100;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    t_out_item want;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (frame_result_q.size() == 0) begin
                $error("result item with nothing expected: frame %0d status %0d",
                       o_out_data.frame, o_out_data.status);
                error_count++;
            end else begin
                want = frame_result_q.pop_front();
                if (o_out_data.frame !== want.frame) begin
                    $error("frame: expected %0d actual %0d", want.frame, o_out_data.frame);
                    error_count++;
                end
                if (o_out_data.status !== want.status) begin
                    $error("status: expected %0d actual %0d", want.status,
                           o_out_data.status);
                    error_count++;
                end
            end
            rx_count++;
        end
        if (cycle_count % 64 == 0) begin
            case ($urandom_range(0, 3))
                0: ready_pct = 100;
                1: ready_pct = 70;
                2: ready_pct = 40;
                default: ready_pct = 10;
            endcase
        end
        if (!hold_done && rx_count == 400) begin
            hold_done = 1'b1;
            hold_left = 600;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) < ready_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic wait_idle();
        while (pending_items.size() > 0 || i_in_valid || frame_result_q.size() > 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_first_frame(logic [15:0] value);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (!shadow_table_on) shadow_bump = value;
        @(posedge i_clk);
    endtask

    initial begin
        for (int k = 0; k < NFRAMES; k++) shadow_status[k] = ST_NONE;
        shadow_table_on = 1'b0;
        shadow_bump     = FIRST_RESET;
        shadow_top      = 0;
        shadow_hint     = 0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // bump mode
        pending_items.push_back(mk_item(K_REGION, 0, 100, RT_RAM));     // ends below 256
        pending_items.push_back(mk_item(K_REGION, 0, 256, RT_RAM));
        pending_items.push_back(mk_item(K_REGION, 256, 1800, RT_RAM));
        pending_items.push_back(mk_item(K_REGION, 1000, 16, RT_RESERVED));
        pending_items.push_back(mk_item(K_REGION, 1100, 8, RT_ACPI));
        pending_items.push_back(mk_item(K_REGION, 1200, 4, RT_NVS));
        pending_items.push_back(mk_item(K_REGION, 600, 20, 4));
        pending_items.push_back(mk_item(K_REGION, 700, 20, 7));
        pending_items.push_back(mk_item(K_ALLOC, 0, 0, 0));
        pending_items.push_back(mk_item(K_ALLOC, 0, 4, 0));
        pending_items.push_back(mk_item(K_ALLOC, 0, 65536, 0));         // bump overflow
        pending_items.push_back(mk_item(K_FREE, 1000, 0, 0));
        write_first_frame(16'hFFFF);
        pending_items.push_back(mk_item(K_ALLOC, 65535, 1, 0));
        pending_items.push_back(mk_item(K_ALLOC, 65535, 1, 0));
        write_first_frame(16'h0000);
        pending_items.push_back(mk_item(K_ALLOC, 0, 300, 0));
        // regions running past the table, then one more RAM region inside it
        pending_items.push_back(mk_item(K_REGION, 65500, 65536, RT_RESERVED));
        pending_items.push_back(mk_item(K_REGION, 65500, 100, RT_RAM));
        pending_items.push_back(mk_item(K_REGION, 256, 2000, RT_RAM));
        // table mode
        pending_items.push_back(mk_item(K_ENABLE, 0, 1, 0));
        pending_items.push_back(mk_item(K_ENABLE, 0, 1, 0));
        pending_items.push_back(mk_item(K_ALLOC, 0, 8, 0));
        pending_items.push_back(mk_item(K_ALLOC, 0, 60000, 0));         // no run fits
        pending_items.push_back(mk_item(K_FREE, 65530, 100, 0));
        pending_items.push_back(mk_item(K_FREE, 500, 0, 0));
        pending_items.push_back(mk_item(K_ALLOC, 0, 3, 0));

        for (int seg = 0; seg < 4; seg++) begin
            case (seg)
                0: write_first_frame(16'hFFFF);
                1: write_first_frame(16'h0000);
                2: write_first_frame(16'($urandom_range(0, 65535)));
                default: write_first_frame(FIRST_RESET);
            endcase
            for (int n = 0; n < N_RANDOM / 4; n++) begin
                pending_items.push_back(rand_item());
                if (seg == 2 && n == N_RANDOM / 8) wait_idle();
            end
        end

        wait_idle();
        repeat (50) @(posedge i_clk);
        if (frame_result_q.size() != 0) begin
            $error("%0d expected result items never arrived", frame_result_q.size());
            error_count++;
        end
        $display("items: %0d region, %0d enable, %0d alloc (%0d refused), %0d free",
                 kind_count[0], kind_count[1], kind_count[2], alloc_fail_count,
                 kind_count[3]);
        $display("%0d result items checked in %0d cycles, %0d errors",
                 rx_count, cycle_count, error_count);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[files.f]
hw/rtl/pfa_pkg.sv
hw/rtl/pfa_ram.sv
hw/rtl/pfa_ctrl.sv
hw/rtl/page_frame_allocator_core.sv
tb/sv/page_frame_allocator_core_tb.sv
